>>> rtl/assert_macros.svh
// Assertion macros shared by the modulator RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define OVF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition on one edge implies a consequence on the next edge
`define OVF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/ovf_pkg.sv
// Shared types, constants and helper functions for the V/f modulator.
// No dependencies; used by ovf_mul, ovf_seq and the core top level.
`timescale 1ns / 1ps

package ovf_pkg;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 30;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Fixed constants of the transforms
	localparam logic signed [31:0] POLY_SEED  = 32'sd172272;
	localparam logic [14:0]        SQRT3_HALF = 15'd28378;
	localparam logic [15:0]        DUTY_FULL  = 16'h7FFF;

	// Sequencer step numbering
	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_INCR  = 5'd0;
	localparam step_t ST_SIN   = 5'd1;
	localparam step_t ST_COS   = 5'd7;
	localparam step_t ST_ALPHA = 5'd13;
	localparam step_t ST_BETA  = 5'd14;
	localparam step_t ST_SB    = 5'd15;
	localparam step_t ST_DUTY  = 5'd16;
	localparam step_t ST_SPEED = 5'd19;
	localparam step_t ST_LAST  = 5'd19;

	// Offsets inside one sine evaluation
	localparam step_t SUB_SQ  = 5'd0;
	localparam step_t SUB_P0  = 5'd1;
	localparam step_t SUB_FIN = 5'd5;

	// Operation carried out by one multiply/write-back pair
	typedef enum logic [3:0] {
		OP_INCR,
		OP_SQ,
		OP_POLY,
		OP_FIN,
		OP_ALPHA,
		OP_BETA,
		OP_SB,
		OP_DUTY,
		OP_SPEED
	} op_t;

	typedef struct packed {
		op_t        kind;
		logic       cosine;
		logic [1:0] idx;
	} op_dec_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_RAMP_STEP,
		REG_ANGLE_GAIN,
		REG_UQ_LEVEL,
		REG_PWM_PERIOD,
		REG_SLOW_DIVIDE,
		REG_UNWRAP_LIMIT,
		REG_SPEED_SCALE
	} reg_idx_t;

	// Sequencer to datapath control
	typedef struct packed {
		step_t step;
		logic  accept;
		logic  mul;
		logic  wb;
		logic  fin;
	} seq_ctl_t;

	// Map a step number onto its operation
	function automatic op_dec_t op_decode(input step_t s);
		op_dec_t d;
		step_t   rel;
		d.kind   = OP_INCR;
		d.cosine = 1'b0;
		d.idx    = 2'd0;
		rel      = '0;
		if (s == ST_INCR) begin
			d.kind = OP_INCR;
		end else if (s < ST_ALPHA) begin
			d.cosine = (s >= ST_COS);
			rel = d.cosine ? step_t'(s - ST_COS) : step_t'(s - ST_SIN);
			if (rel == SUB_SQ) begin
				d.kind = OP_SQ;
			end else if (rel == SUB_FIN) begin
				d.kind = OP_FIN;
			end else begin
				d.kind = OP_POLY;
				d.idx  = 2'(rel - SUB_P0);
			end
		end else if (s == ST_ALPHA) begin
			d.kind = OP_ALPHA;
		end else if (s == ST_BETA) begin
			d.kind = OP_BETA;
		end else if (s == ST_SB) begin
			d.kind = OP_SB;
		end else if (s < ST_SPEED) begin
			d.kind = OP_DUTY;
			d.idx  = 2'(s - ST_DUTY);
		end else begin
			d.kind = OP_SPEED;
		end
		return d;
	endfunction

	// Horner coefficients of the quarter-wave sine, Q30
	function automatic logic signed [31:0] poly_coef(input logic [1:0] i);
		logic signed [31:0] c;
		case (i)
			2'd0:    c = -32'sd5026995;
			2'd1:    c = 32'sd85569306;
			2'd2:    c = -32'sd693598668;
			default: c = 32'sd1686629713;
		endcase
		return c;
	endfunction

	// Phase value -1..1 (Q15) to duty level 0..32767
	function automatic logic [14:0] duty_level(input logic signed [17:0] x);
		logic signed [18:0] t;
		logic [14:0]        d;
		t = 19'(x) + 19'sd32768;
		if (t <= 19'sd0)
			d = 15'd0;
		else if (t[18:1] > 18'd32767)
			d = 15'h7FFF;
		else
			d = t[15:1];
		return d;
	endfunction

endpackage

>>> rtl/ovf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ovf_pkg for operand widths.
`timescale 1ns / 1ps

module ovf_mul import ovf_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	// One product per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

>>> rtl/ovf_seq.sv
// Step sequencer: walks the multiply/write-back program for one item.
// Depends on ovf_pkg for the step numbering and control struct.
`timescale 1ns / 1ps

module ovf_seq import ovf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_busy,
	output logic     in_stall,
	output seq_ctl_t ctl
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_WB   = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	step_t  step_q;

	// Control decode
	always_comb begin
		ctl.step   = step_q;
		ctl.accept = (state_q == S_IDLE) && in_valid;
		ctl.mul    = (state_q == S_MUL);
		ctl.wb     = (state_q == S_WB);
		ctl.fin    = (state_q == S_FIN) && !out_busy;
		in_stall   = (state_q != S_IDLE);
	end

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_INCR;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
						step_q  <= ST_INCR;
					end
				end
				S_MUL: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (step_q == ST_LAST) begin
						state_q <= S_FIN;
					end else begin
						step_q  <= step_t'(step_q + step_t'(1));
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					if (!out_busy) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/open_loop_volts_per_hertz_modulator_core.sv
// Open-loop V/f modulator top level: config registers, datapath, outputs.
// Depends on ovf_pkg, ovf_mul, ovf_seq and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each accepted item is one PWM tick and yields exactly one result item.
// An item runs from acceptance to the next possible acceptance through an
// accept step, twenty multiply/write-back pairs on the single shared 32x30
// multiplier (angle step, two 9th-order sine polynomials, inverse Park and
// Clarke, three duty scalings, speed measurement) and a finish step that
// commits state and loads the output register once the previous result
// has left it. in_stall is high while an item is in work; the result waits
// in the output register, and the next item may be accepted while it does.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should only be made while the block is idle.
module open_loop_volts_per_hertz_modulator_core import ovf_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [14:0] target_speed,
	input  logic signed [15:0] mech_angle,
	// result items
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        duty_a,
	output logic [15:0]        duty_b,
	output logic [15:0]        duty_c,
	output logic signed [15:0] electrical_angle,
	output logic signed [14:0] commanded_speed,
	output logic signed [15:0] measured_speed,
	output logic               speed_updated
);

	localparam int          QSHIFT = 16 - SINE_TABLE_BITS;
	localparam logic [15:0] QMASK  = 16'(17'h1_0000 - (17'd1 << QSHIFT));

	// configuration registers
	logic [13:0] ramp_step_q;
	logic [15:0] angle_gain_q;
	logic [14:0] uq_level_q;
	logic [15:0] pwm_period_q;
	logic [15:0] slow_divide_q;
	logic [14:0] unwrap_limit_q;
	logic [15:0] speed_scale_q;

	// persistent state
	logic signed [14:0] speed_cmd_q;
	logic [15:0]        angle_q;
	logic [15:0]        tick_count_q;
	logic signed [15:0] prev_angle_q;
	logic signed [31:0] angle_sum_q;
	logic signed [15:0] speed_meas_q;

	// captured item and work registers
	logic signed [14:0] target_q;
	logic signed [15:0] mech_q;
	logic [28:0]        u2_q;
	logic signed [31:0] acc_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;
	logic signed [15:0] alpha_q;
	logic signed [15:0] beta_q;
	logic [14:0]        lvl_a_q, lvl_b_q, lvl_c_q;
	logic [15:0]        cnt_a_q, cnt_b_q, cnt_c_q;
	logic signed [15:0] meas_next_q;

	// output register
	logic               out_valid_q;
	logic [15:0]        duty_a_q, duty_b_q, duty_c_q;
	logic signed [15:0] elec_angle_q;
	logic signed [14:0] cmd_speed_q;
	logic signed [15:0] meas_speed_q;
	logic               updated_q;

	seq_ctl_t                  ctl;
	op_dec_t                   dec;
	logic                      out_busy;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	assign out_busy  = out_valid_q && out_stall;
	assign cfg_ready = 1'b1;
	assign dec       = op_decode(ctl.step);

	ovf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	ovf_mul u_mul (
		.clk (clk),
		.en  (ctl.mul),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// sine argument: quantised angle folded into the first quadrant
	logic [15:0] sin_arg;
	logic [15:0] sin_qarg;
	logic [14:0] u_eff;
	logic        sin_neg;

	always_comb begin
		sin_arg  = dec.cosine ? 16'(angle_q + 16'd16384) : angle_q;
		sin_qarg = sin_arg & QMASK;
		u_eff    = sin_qarg[14] ? 15'(15'd16384 - {1'b0, sin_qarg[13:0]})
		                        : {1'b0, sin_qarg[13:0]};
		sin_neg  = sin_qarg[15];
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (dec.kind)
			OP_INCR: begin
				mul_a = 32'(speed_cmd_q);
				mul_b = {14'd0, angle_gain_q};
			end
			OP_SQ: begin
				mul_a = {17'd0, u_eff};
				mul_b = {15'd0, u_eff};
			end
			OP_POLY: begin
				mul_a = acc_q;
				mul_b = {1'b0, u2_q};
			end
			OP_FIN: begin
				mul_a = acc_q;
				mul_b = {15'd0, u_eff};
			end
			OP_ALPHA: begin
				mul_a = {17'd0, uq_level_q};
				mul_b = 30'(sin_q);
			end
			OP_BETA: begin
				mul_a = {17'd0, uq_level_q};
				mul_b = 30'(cos_q);
			end
			OP_SB: begin
				mul_a = 32'(beta_q);
				mul_b = {15'd0, SQRT3_HALF};
			end
			OP_DUTY: begin
				mul_a = {16'd0, pwm_period_q};
				case (dec.idx)
					2'd0:    mul_b = {15'd0, lvl_a_q};
					2'd1:    mul_b = {15'd0, lvl_b_q};
					default: mul_b = {15'd0, lvl_c_q};
				endcase
			end
			OP_SPEED: begin
				mul_a = angle_sum_q;
				mul_b = {14'd0, speed_scale_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product rounded toward zero before the right shift of each shifted operation
	logic signed [MUL_P_W-1:0] bias;
	logic signed [MUL_P_W-1:0] pb;

	always_comb begin
		case (dec.kind)
			OP_INCR, OP_SPEED:        bias = 62'sd65535;
			OP_POLY:                  bias = 62'sd268435455;
			OP_FIN:                   bias = 62'sd16383;
			OP_ALPHA, OP_BETA, OP_SB: bias = 62'sd32767;
			default:                  bias = 62'sd0;
		endcase
		pb = mul_p + (mul_p[MUL_P_W-1] ? bias : 62'sd0);
	end

	// sine finish: Q30 to Q15 with round half up and clamp
	logic signed [31:0] s_fin;
	logic signed [32:0] t_fin;
	logic [14:0]        r_fin;
	logic signed [15:0] v_fin;

	always_comb begin
		s_fin = pb[45:14];
		t_fin = 33'(s_fin) + 33'sd16384;
		if (t_fin < 33'sd0)
			r_fin = 15'd0;
		else if (t_fin[32:15] > 18'd32767)
			r_fin = 15'h7FFF;
		else
			r_fin = t_fin[29:15];
		v_fin = sin_neg ? 16'sd0 - $signed({1'b0, r_fin}) : $signed({1'b0, r_fin});
	end

	// inverse Clarke from alpha and the scaled beta
	logic signed [16:0] a_bias;
	logic signed [15:0] half_a;
	logic signed [15:0] sb;
	logic signed [17:0] x_b, x_c;

	always_comb begin
		a_bias = 17'(alpha_q) + $signed({16'd0, alpha_q[15]});
		half_a = 16'(a_bias >>> 1);
		sb     = pb[30:15];
		x_b    = 18'(sb) - 18'(half_a);
		x_c    = 18'sd0 - 18'(half_a) - 18'(sb);
	end

	// duty count: product divided by 0x7FFF with one correction
	logic [30:0] dx;
	logic [31:0] dsum;
	logic [16:0] dq0;
	logic [31:0] drem;
	logic [16:0] dq;

	always_comb begin
		dx   = mul_p[30:0];
		dsum = {1'b0, dx} + 32'(dx[30:15]);
		dq0  = dsum[31:15];
		drem = {1'b0, dx} - ({dq0[16:0], 15'd0} - 32'(dq0));
		dq   = (drem >= 32'(DUTY_FULL)) ? 17'(dq0 + 17'd1) : dq0;
	end

	// measured speed, saturated to 16 bits
	logic signed [31:0] m32;
	logic signed [15:0] m_sat;

	always_comb begin
		m32 = pb[47:16];
		if (m32 > 32'sd32767)
			m_sat = 16'sh7FFF;
		else if (m32 < -32'sd32768)
			m_sat = 16'sh8000;
		else
			m_sat = m32[15:0];
	end

	// fast tick: unwrapped angle change into the window sum
	logic signed [16:0] ang_d;
	logic signed [16:0] ang_lim;
	logic signed [17:0] ang_u;
	logic signed [32:0] sum33;
	logic signed [31:0] sum_sat;

	always_comb begin
		ang_d   = 17'(mech_q) - 17'(prev_angle_q);
		ang_lim = $signed({2'b00, unwrap_limit_q});
		if (ang_d < -ang_lim)
			ang_u = 18'(ang_d) + 18'sd65536;
		else if (ang_d > ang_lim)
			ang_u = 18'(ang_d) - 18'sd65536;
		else
			ang_u = 18'(ang_d);
		sum33 = 33'(angle_sum_q) + 33'(ang_u);
		if (sum33 > 33'sd2147483647)
			sum_sat = 32'sh7FFFFFFF;
		else if (sum33 < -33'sd2147483648)
			sum_sat = 32'sh80000000;
		else
			sum_sat = sum33[31:0];
	end

	// slow tick: ramp the speed command toward the target
	logic               slow;
	logic signed [15:0] cmd_up;
	logic signed [15:0] cmd_step;
	logic signed [14:0] cmd_next;

	always_comb begin
		slow     = !(tick_count_q < slow_divide_q);
		cmd_up   = 16'(target_q) - 16'(speed_cmd_q);
		cmd_step = $signed({2'b00, ramp_step_q});
		if (speed_cmd_q <= target_q)
			cmd_next = (cmd_up < cmd_step) ? target_q : 15'(16'(speed_cmd_q) + cmd_step);
		else
			cmd_next = ((16'sd0 - cmd_up) < cmd_step) ? target_q
			                                           : 15'(16'(speed_cmd_q) - cmd_step);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q    <= 14'd10;
			angle_gain_q   <= 16'd0;
			uq_level_q     <= 15'd0;
			pwm_period_q   <= 16'd1000;
			slow_divide_q  <= 16'd10;
			unwrap_limit_q <= 15'd16384;
			speed_scale_q  <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RAMP_STEP:    ramp_step_q    <= cfg_data[13:0];
				REG_ANGLE_GAIN:   angle_gain_q   <= cfg_data;
				REG_UQ_LEVEL:     uq_level_q     <= cfg_data[14:0];
				REG_PWM_PERIOD:   pwm_period_q   <= cfg_data;
				REG_SLOW_DIVIDE:  slow_divide_q  <= cfg_data;
				REG_UNWRAP_LIMIT: unwrap_limit_q <= cfg_data[14:0];
				REG_SPEED_SCALE:  speed_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// persistent state: angle step on write-back, window and ramp on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_cmd_q  <= '0;
			angle_q      <= '0;
			tick_count_q <= '0;
			prev_angle_q <= '0;
			angle_sum_q  <= '0;
			speed_meas_q <= '0;
		end else begin
			if (ctl.wb && dec.kind == OP_INCR) begin
				angle_q <= 16'(angle_q + pb[31:16]);
			end
			if (ctl.fin) begin
				if (slow) begin
					speed_meas_q <= meas_next_q;
					angle_sum_q  <= '0;
					tick_count_q <= '0;
					speed_cmd_q  <= cmd_next;
				end else begin
					if (tick_count_q != 16'd0) angle_sum_q <= sum_sat;
					prev_angle_q <= mech_q;
					tick_count_q <= 16'(tick_count_q + 16'd1);
				end
			end
		end
	end

	// item capture and work registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			target_q <= target_speed;
			mech_q   <= mech_angle;
		end
		if (ctl.wb) begin
			case (dec.kind)
				OP_SQ: begin
					u2_q  <= mul_p[28:0];
					acc_q <= POLY_SEED;
				end
				OP_POLY: begin
					acc_q <= 32'(poly_coef(dec.idx) + pb[59:28]);
				end
				OP_FIN: begin
					if (dec.cosine) cos_q <= v_fin;
					else            sin_q <= v_fin;
				end
				OP_ALPHA: begin
					alpha_q <= 16'sd0 - pb[30:15];
				end
				OP_BETA: begin
					beta_q <= pb[30:15];
				end
				OP_SB: begin
					lvl_a_q <= duty_level(18'(alpha_q));
					lvl_b_q <= duty_level(x_b);
					lvl_c_q <= duty_level(x_c);
				end
				OP_DUTY: begin
					case (dec.idx)
						2'd0:    cnt_a_q <= dq[15:0];
						2'd1:    cnt_b_q <= dq[15:0];
						default: cnt_c_q <= dq[15:0];
					endcase
				end
				OP_SPEED: begin
					meas_next_q <= m_sat;
				end
				default: ;
			endcase
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			duty_a_q     <= cnt_a_q;
			duty_b_q     <= cnt_b_q;
			duty_c_q     <= cnt_c_q;
			elec_angle_q <= $signed(angle_q);
			cmd_speed_q  <= slow ? cmd_next : speed_cmd_q;
			meas_speed_q <= slow ? meas_next_q : speed_meas_q;
			updated_q    <= slow;
		end
	end

	assign out_valid        = out_valid_q;
	assign duty_a           = duty_a_q;
	assign duty_b           = duty_b_q;
	assign duty_c           = duty_c_q;
	assign electrical_angle = elec_angle_q;
	assign commanded_speed  = cmd_speed_q;
	assign measured_speed   = meas_speed_q;
	assign speed_updated    = updated_q;

	// checks
	`OVF_ASSERT_NEXT(a_busy_after_accept, ctl.accept, in_stall, "item accepted but block not busy")
	`OVF_ASSERT(a_sum_clear_at_window, (tick_count_q == 16'd0) |-> (angle_sum_q == 32'sd0), "angle sum not clear at window start")
	`OVF_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(ctl.fin), "result raised without a finished item")

endmodule
